/* src/cldi_pkg.sv */
package cldi_pkg;

   // Field widths of the item and result channels
   localparam int LINE_W  = 24;
   localparam int BYTE_W  = 16;
   localparam int PIX_W   = 8;
   localparam int COLOR_W = 2;
   localparam int INDEX_W = LINE_W + 1;   // signed color line index
   localparam int ACC_W   = 14;
   localparam int RES_W   = 13;
   localparam int DELAY_W = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACC_MODULUS = 3'd0,
      CSR_ACC_STEP    = 3'd1,
      CSR_RED_DELAY   = 3'd2,
      CSR_GREEN_DELAY = 3'd3,
      CSR_BLUE_DELAY  = 3'd4,
      CSR_LINE_BYTES  = 3'd5,
      CSR_TOTAL_LINES = 3'd6
   } csr_index_type;

   // Color codes
   localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd0;
   localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd1;
   localparam logic [COLOR_W-1:0] COLOR_BLUE  = 2'd2;

   localparam logic [ACC_W-1:0] ACC_MAX = 14'h3FFF;
   localparam logic [RES_W-1:0] RES_RESET = 13'd1200;

   // 2^17 / 3 rounded up: exact floor division by three for 16-bit values
   localparam logic [16:0] DIV3_RECIP = 17'd43691;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOAD   = 2'd1,
      ST_SEARCH = 2'd2,
      ST_EMIT   = 2'd3
   } state_type;

   typedef struct packed {
      logic accept;   // latch the incoming item
      logic load;     // load start indices and accumulators
      logic step;     // one slot rotation
      logic emit;     // place the item and write the result register
   } cmd_type;

   typedef struct packed {
      logic loaded;
      logic need_search;
      logic search_end;
      logic out_free;
   } status_type;

   // Slot rotation order: green, blue, red
   function automatic logic [COLOR_W-1:0] slot_colour(input logic [1:0] slot);
      logic [COLOR_W-1:0] c;
      case (slot)
         2'd0:    c = COLOR_GREEN;
         2'd1:    c = COLOR_BLUE;
         2'd2:    c = COLOR_RED;
         default: c = COLOR_RED;
      endcase
      return c;
   endfunction

endpackage

/* src/cldi_ctrl.sv */
module cldi_ctrl
   import cldi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!status.loaded) begin
                  state_in = ST_LOAD;
               end else if (status.need_search) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_LOAD: begin
            state_in = status.need_search ? ST_SEARCH : ST_EMIT;
         end
         ST_SEARCH: begin
            if (status.search_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_LOAD:   cmd.load = 1'b1;
         ST_SEARCH: cmd.step = 1'b1;
         ST_EMIT:   cmd.emit = status.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

/* src/cldi_datapath.sv */
module cldi_datapath
   import cldi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [PIX_W-1:0]      req_raw_byte,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_pixel_byte,
   output logic [LINE_W-1:0]     rsp_out_line,
   output logic [BYTE_W-1:0]     rsp_out_offset,
   output logic [COLOR_W-1:0]    rsp_color,
   output logic [LINE_W-1:0]     rsp_lines_complete,
   output logic                  rsp_line_end,
   output logic                  rsp_accepted,
   output logic                  rsp_finished
);

   // Configuration registers
   logic [RES_W-1:0]   modulus_ff, modulus_in;
   logic [RES_W-1:0]   acc_step_ff, acc_step_in;
   logic [DELAY_W-1:0] red_delay_ff, red_delay_in;
   logic [DELAY_W-1:0] green_delay_ff, green_delay_in;
   logic [DELAY_W-1:0] blue_delay_ff, blue_delay_in;
   logic [BYTE_W-1:0]  pixels_ff, pixels_in;
   logic [LINE_W-1:0]  total_lines_ff, total_lines_in;

   // Scan state
   logic [1:0]                slot_ff, slot_in;
   logic signed [INDEX_W-1:0] idx_ff [3];
   logic signed [INDEX_W-1:0] idx_in [3];
   logic [ACC_W-1:0]          acc_ff [3];
   logic [ACC_W-1:0]          acc_in [3];
   logic [BYTE_W-1:0]         byte_ff, byte_in;
   logic [COLOR_W-1:0]        cur_colour_ff, cur_colour_in;
   logic [LINE_W-1:0]         cur_line_ff, cur_line_in;
   logic                      done_ff, done_in;
   logic                      loaded_ff, loaded_in;
   logic [PIX_W-1:0]          raw_ff, raw_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    rsp_pixel_ff, rsp_pixel_in;
   logic [LINE_W-1:0]   rsp_line_ff, rsp_line_in;
   logic [BYTE_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic [LINE_W-1:0]   rsp_lc_ff, rsp_lc_in;
   logic                rsp_lend_ff, rsp_lend_in;
   logic                rsp_acc_ff, rsp_acc_in;
   logic                rsp_fin_ff, rsp_fin_in;

   // Search step terms
   logic signed [INDEX_W-1:0] total_s, idx_sel;
   logic                      all_reached, idx_neg, idx_below, pass, hit;
   logic [1:0]                slot_nx;
   logic [COLOR_W-1:0]        c_sel;
   logic [ACC_W-1:0]          acc_sel, acc_sat;
   logic [RES_W-1:0]          inc;
   logic [ACC_W:0]            sum, diff;

   // Emit terms
   logic [BYTE_W-1:0]  byte_nx, offset;
   logic               lend;
   logic [LINE_W-1:0]  blue_lc;
   logic [BYTE_W+16:0] div_prod;
   logic [BYTE_W-1:0]  div_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= RES_RESET;
         acc_step_ff    <= RES_RESET;
         red_delay_ff   <= '0;
         green_delay_ff <= '0;
         blue_delay_ff  <= '0;
         pixels_ff      <= BYTE_W'(1);
         total_lines_ff <= LINE_W'(1);
         slot_ff        <= 2'd2;
         byte_ff        <= '0;
         cur_colour_ff  <= COLOR_RED;
         cur_line_ff    <= '0;
         done_ff        <= 1'b0;
         loaded_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         modulus_ff     <= modulus_in;
         acc_step_ff    <= acc_step_in;
         red_delay_ff   <= red_delay_in;
         green_delay_ff <= green_delay_in;
         blue_delay_ff  <= blue_delay_in;
         pixels_ff      <= pixels_in;
         total_lines_ff <= total_lines_in;
         slot_ff        <= slot_in;
         byte_ff        <= byte_in;
         cur_colour_ff  <= cur_colour_in;
         cur_line_ff    <= cur_line_in;
         done_ff        <= done_in;
         loaded_ff      <= loaded_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Indices and accumulators are loaded before first use
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         idx_ff[i] <= idx_in[i];
         acc_ff[i] <= acc_in[i];
      end
      raw_ff        <= raw_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_line_ff   <= rsp_line_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_lc_ff     <= rsp_lc_in;
      rsp_lend_ff   <= rsp_lend_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   // Configuration writes; pixels per raw line is line_bytes / 3, at least one
   always_comb begin
      modulus_in     = modulus_ff;
      acc_step_in    = acc_step_ff;
      red_delay_in   = red_delay_ff;
      green_delay_in = green_delay_ff;
      blue_delay_in  = blue_delay_ff;
      pixels_in      = pixels_ff;
      total_lines_in = total_lines_ff;
      div_prod = {17'd0, csr_wdata[BYTE_W-1:0]} * {{BYTE_W{1'b0}}, DIV3_RECIP};
      div_q    = div_prod[BYTE_W+16:17];
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ACC_MODULUS: modulus_in     = csr_wdata[RES_W-1:0];
            CSR_ACC_STEP:    acc_step_in    = csr_wdata[RES_W-1:0];
            CSR_RED_DELAY:   red_delay_in   = csr_wdata[DELAY_W-1:0];
            CSR_GREEN_DELAY: green_delay_in = csr_wdata[DELAY_W-1:0];
            CSR_BLUE_DELAY:  blue_delay_in  = csr_wdata[DELAY_W-1:0];
            CSR_LINE_BYTES:  pixels_in      = (div_q == '0) ? BYTE_W'(1) : div_q;
            CSR_TOTAL_LINES: total_lines_in = csr_wdata[LINE_W-1:0];
            default:         modulus_in     = modulus_ff;
         endcase
      end
   end

   // One slot rotation
   always_comb begin
      total_s     = $signed({1'b0, total_lines_ff});
      all_reached = (idx_ff[0] >= total_s) && (idx_ff[1] >= total_s) &&
                    (idx_ff[2] >= total_s);
      slot_nx     = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
      c_sel       = slot_colour(slot_nx);
      case (c_sel)
         COLOR_RED: begin
            idx_sel = idx_ff[0];
            acc_sel = acc_ff[0];
         end
         COLOR_GREEN: begin
            idx_sel = idx_ff[1];
            acc_sel = acc_ff[1];
         end
         default: begin
            idx_sel = idx_ff[2];
            acc_sel = acc_ff[2];
         end
      endcase
      inc       = (acc_step_ff == '0) ? RES_W'(1) : acc_step_ff;
      sum       = {1'b0, acc_sel} + {2'b00, inc};
      pass      = sum > {2'b00, modulus_ff};
      diff      = sum - {2'b00, modulus_ff};
      acc_sat   = (diff > {1'b0, ACC_MAX}) ? ACC_MAX : diff[ACC_W-1:0];
      idx_neg   = idx_sel[INDEX_W-1];
      idx_below = idx_sel < total_s;
      hit       = !all_reached && !idx_neg && idx_below && pass;
   end

   // Placement of one byte
   always_comb begin
      byte_nx = byte_ff + BYTE_W'(1);
      lend    = (byte_nx >= pixels_ff) || (byte_nx == '0);
      offset  = {byte_ff[BYTE_W-2:0], 1'b0} + byte_ff +
                {{(BYTE_W-COLOR_W){1'b0}}, cur_colour_ff};
      blue_lc = (!idx_ff[2][INDEX_W-1] && (idx_ff[2] != '0)) ?
                idx_ff[2][LINE_W-1:0] : '0;
   end

   always_comb begin
      slot_in       = slot_ff;
      byte_in       = byte_ff;
      cur_colour_in = cur_colour_ff;
      cur_line_in   = cur_line_ff;
      done_in       = done_ff;
      loaded_in     = loaded_ff;
      raw_in        = raw_ff;
      for (int i = 0; i < 3; i++) begin
         idx_in[i] = idx_ff[i];
         acc_in[i] = acc_ff[i];
      end
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_line_in   = rsp_line_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_lc_in     = rsp_lc_ff;
      rsp_lend_in   = rsp_lend_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.accept) begin
         raw_in = req_raw_byte;
      end

      if (cmd.load) begin
         idx_in[0] = -$signed({{(INDEX_W-DELAY_W){1'b0}}, red_delay_ff});
         idx_in[1] = -$signed({{(INDEX_W-DELAY_W){1'b0}}, green_delay_ff});
         idx_in[2] = -$signed({{(INDEX_W-DELAY_W){1'b0}}, blue_delay_ff});
         for (int i = 0; i < 3; i++) begin
            acc_in[i] = {1'b0, modulus_ff};
         end
         loaded_in = 1'b1;
      end

      if (cmd.step) begin
         if (all_reached) begin
            done_in = 1'b1;
         end else begin
            slot_in = slot_nx;
            if (idx_neg) begin
               idx_in[c_sel] = idx_sel + INDEX_W'(1);
            end else if (idx_below) begin
               if (pass) begin
                  acc_in[c_sel] = acc_sat;
                  cur_colour_in = c_sel;
                  cur_line_in   = idx_sel[LINE_W-1:0];
                  idx_in[c_sel] = idx_sel + INDEX_W'(1);
               end else begin
                  acc_in[c_sel] = sum[ACC_W-1:0];
               end
            end
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = raw_ff;
         rsp_lc_in    = blue_lc;
         if (done_ff) begin
            rsp_line_in   = '0;
            rsp_offset_in = '0;
            rsp_color_in  = COLOR_RED;
            rsp_lend_in   = 1'b0;
            rsp_acc_in    = 1'b0;
            rsp_fin_in    = 1'b1;
         end else begin
            rsp_line_in   = cur_line_ff;
            rsp_offset_in = offset;
            rsp_color_in  = cur_colour_ff;
            rsp_lend_in   = lend;
            rsp_acc_in    = 1'b1;
            rsp_fin_in    = lend && all_reached;
            byte_in       = lend ? '0 : byte_nx;
            if (lend && all_reached) begin
               done_in = 1'b1;
            end
         end
      end
   end

   assign status.loaded      = loaded_ff;
   assign status.need_search = !done_ff && (byte_ff == '0);
   assign status.search_end  = all_reached || hit;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_byte     = rsp_pixel_ff;
   assign rsp_out_line       = rsp_line_ff;
   assign rsp_out_offset     = rsp_offset_ff;
   assign rsp_color          = rsp_color_ff;
   assign rsp_lines_complete = rsp_lc_ff;
   assign rsp_line_end       = rsp_lend_ff;
   assign rsp_accepted       = rsp_acc_ff;
   assign rsp_finished       = rsp_fin_ff;

endmodule

/* src/ccd_line_distance_interleaver_unit.sv */
// Sequence: an item taken in the idle state goes to the emit state, which writes
//   the output register; the first item after reset passes the load state first,
//   and an item that opens a raw line passes the search state, one step per color
//   slot rotated (delay lines being worked off count), until a hit or until the
//   stream turns out finished; a stalled result holds the emit state. Items are
//   taken only when idle; the output register lets the next item in meanwhile.
// Reset: synchronous, active high; control and configuration registers return to defaults, stream restarts.
module ccd_line_distance_interleaver_unit
   import cldi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // raw byte items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_raw_byte,
   // placed byte items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_pixel_byte,
   output logic [LINE_W-1:0]     rsp_out_line,
   output logic [BYTE_W-1:0]     rsp_out_offset,
   output logic [COLOR_W-1:0]    rsp_color,
   output logic [LINE_W-1:0]     rsp_lines_complete,
   output logic                  rsp_line_end,
   output logic                  rsp_accepted,
   output logic                  rsp_finished
);

   // Controller sequences accept, start load, slot search and emit;
   // the datapath holds configuration, scan state and the output register.
   cmd_type    cmd;
   status_type status;

   cldi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cldi_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_raw_byte       (req_raw_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_byte     (rsp_pixel_byte),
      .rsp_out_line       (rsp_out_line),
      .rsp_out_offset     (rsp_out_offset),
      .rsp_color          (rsp_color),
      .rsp_lines_complete (rsp_lines_complete),
      .rsp_line_end       (rsp_line_end),
      .rsp_accepted       (rsp_accepted),
      .rsp_finished       (rsp_finished)
   );

endmodule
